/* rtl/sbd_pkg.sv */
package sbd_pkg;

    // Width of the two's complement input value.
    localparam int VALUE_BITS = 32;

    // Decimal digits that cover the largest magnitude, 2**(VALUE_BITS-1).
    // 1233/4096 lies just below log10(2), but scaling VALUE_BITS, not VALUE_BITS-1, keeps this from falling short.
    localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS = DIGITS * 4;

    // Counter widths for the conversion and the digit walk.
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam int LEFT_BITS = $clog2(DIGITS);

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHAR_BITS = 6;
    localparam int OUT_TDATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

    localparam logic [VALUE_BITS-1:0] MAG_ONE = {{(VALUE_BITS-1){1'b0}}, 1'b1};

    // One classified value waiting for conversion.
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } entry_t;

endpackage

/* rtl/sbd_front.sv */
module sbd_front (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sbd_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,   // value
    input  logic                               queue_full,
    output logic                               push,
    output sbd_pkg::entry_t                    entry
);

    logic [sbd_pkg::VALUE_BITS-1:0] raw;

    // Split the value into sign and unsigned magnitude.
    always_comb
    begin
        raw = s_axis_tdata[sbd_pkg::VALUE_BITS-1:0];
        entry.neg = raw[sbd_pkg::VALUE_BITS-1];
        entry.mag = entry.neg ? ((~raw) + sbd_pkg::MAG_ONE) : raw;
    end

    // A transfer is taken whenever the queue has room.
    assign s_axis_tready = !queue_full;
    assign push = s_axis_tvalid && !queue_full;

endmodule

/* rtl/sbd_queue.sv */
module sbd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbd_pkg::entry_t entry_in,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output sbd_pkg::entry_t entry_out
);

    sbd_pkg::entry_t                 slot_reg [sbd_pkg::QUEUE_DEPTH];
    logic [sbd_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [sbd_pkg::QPTR_BITS-1:0]   wr_ptr_next;
    logic [sbd_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [sbd_pkg::QPTR_BITS-1:0]   rd_ptr_next;
    logic [sbd_pkg::QCNT_BITS-1:0]   count_reg;
    logic [sbd_pkg::QCNT_BITS-1:0]   count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full = (count_reg == sbd_pkg::QCNT_BITS'(sbd_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign entry_out = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

/* rtl/sbd_back.sv */
module sbd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  sbd_pkg::entry_t                     q_entry,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sbd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,   // char_code
    output logic                                m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int VB = sbd_pkg::VALUE_BITS;
    localparam int BB = sbd_pkg::BCD_BITS;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [VB-1:0]                      bin_reg;
    logic [VB-1:0]                      bin_next;
    logic [BB-1:0]                      bcd_reg;
    logic [BB-1:0]                      bcd_next;
    logic [BB-1:0]                      bcd_adj;
    logic                               neg_reg;
    logic                               neg_next;
    logic [sbd_pkg::CNT_BITS-1:0]       cnt_reg;
    logic [sbd_pkg::CNT_BITS-1:0]       cnt_next;
    logic [sbd_pkg::LEFT_BITS-1:0]      left_reg;
    logic [sbd_pkg::LEFT_BITS-1:0]      left_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [sbd_pkg::CHAR_BITS-1:0]      out_char_reg;
    logic [sbd_pkg::CHAR_BITS-1:0]      out_char_next;
    logic                               out_last_reg;
    logic                               out_last_next;
    logic                               slot_free;
    logic [3:0]                         top_digit;

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < sbd_pkg::DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    assign top_digit = bcd_reg[BB-1 -: 4];
    assign slot_free = !out_valid_reg || m_axis_tready;

    // Conversion and character sequencing.
    always_comb
    begin
        state_next = state_reg;
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        left_next = left_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    bin_next = q_entry.mag;
                    neg_next = q_entry.neg;
                    bcd_next = '0;
                    cnt_next = sbd_pkg::CNT_BITS'(VB - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BB-2:0], bin_reg[VB-1]};
                bin_next = {bin_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    left_next = sbd_pkg::LEFT_BITS'(sbd_pkg::DIGITS - 1);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && left_reg != '0)
                begin
                    bcd_next = {bcd_reg[BB-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next = sbd_pkg::ASCII_MINUS;
                    out_last_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next = sbd_pkg::ASCII_ZERO + {2'b00, top_digit};
                    out_last_next = (left_reg == '0);
                    bcd_next = {bcd_reg[BB-5:0], 4'd0};
                    if (left_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        left_reg <= left_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(sbd_pkg::OUT_TDATA_BITS - sbd_pkg::CHAR_BITS){1'b0}},
                           out_char_reg};
    assign m_axis_tlast = out_last_reg;

endmodule

/* rtl/signed_binary_to_decimal_ascii_top.sv */
// Flow: each value passes through the queue, then a bit-serial double dabble conversion,
// a skip over leading zeros, an optional minus sign and then its digit characters.
// The converter finishes one value before it takes the next; the double dabble sets the
// bulk of the time per value, and a stall on m_axis_tready holds the character output.
// A two-entry queue lets the input take up to two values while the converter is busy.
// Reset: rst_n is asynchronous and active low; it empties the queue and the output register.
module signed_binary_to_decimal_ascii_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sbd_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sbd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,   // char_code
    output logic                                m_axis_tlast
);

    logic            push;
    logic            queue_full;
    logic            q_valid;
    logic            q_pop;
    sbd_pkg::entry_t front_entry;
    sbd_pkg::entry_t q_entry;

    // Sign and magnitude split.
    sbd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .queue_full    (queue_full),
        .push          (push),
        .entry         (front_entry)
    );

    // Queue between front and back.
    sbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (front_entry),
        .full      (queue_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .entry_out (q_entry)
    );

    // Conversion and character output.
    sbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/sbd_checker.sv */
module sbd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [sbd_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic                                m_axis_tlast
);

    logic                           first_reg;
    logic                           after_minus_reg;
    logic                           xfer;
    logic [sbd_pkg::CHAR_BITS-1:0]  ch;

    assign xfer = m_axis_tvalid && m_axis_tready;
    assign ch = m_axis_tdata[sbd_pkg::CHAR_BITS-1:0];

    // Track the position of the next character within its value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            after_minus_reg <= 1'b0;
        end
        else if (xfer)
        begin
            first_reg <= m_axis_tlast;
            after_minus_reg <= (ch == sbd_pkg::ASCII_MINUS);
        end
    end

    // A stalled character holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Only a minus sign or a digit appears.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ch == sbd_pkg::ASCII_MINUS) ||
            (ch >= sbd_pkg::ASCII_ZERO && ch <= sbd_pkg::ASCII_ZERO + 6'd9))
        else $error("bad character code");

    // A minus sign leads a value and is never its last character.
    a_minus: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ch == sbd_pkg::ASCII_MINUS |-> first_reg && !m_axis_tlast)
        else $error("misplaced minus sign");

    // A leading zero stands alone.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (first_reg || after_minus_reg) && ch == sbd_pkg::ASCII_ZERO
            |-> m_axis_tlast && !after_minus_reg)
        else $error("leading zero emitted");

endmodule

bind signed_binary_to_decimal_ascii_top sbd_checker u_sbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
